>>> rtl/pptif_pkg.sv
// Shared constants and types for the per-pixel temporal IIR filter.
// Holds field widths, register indexes, fixed-point limits and the history row type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pptif_pkg;

  // frame and filter geometry
  localparam int PIXELS    = 4096;
  localparam int MAX_ORDER = 6;
  localparam int NUM_COEF  = 6;
  localparam int ADDR_W    = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  // field widths
  localparam int DATA_W    = 24;
  localparam int INDEX_W   = 12;
  localparam int ORDER_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int COEF_IDX_W = 3;
  localparam int FRAC_W    = 16;

  // arithmetic widths: exact products, exact sum of MAX_ORDER + 1 terms
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + $clog2(MAX_ORDER + 1) + 1;
  localparam int NPAIR  = (MAX_ORDER + 2) / 2;

  localparam int SAT_MAX    = 8388607;
  localparam int SAT_MIN    = -8388608;
  localparam int ROUND_HALF = 32768;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE = 3'd2;

  // reset values
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd1;
  localparam logic [DATA_W-1:0]  GAIN_RESET  = 24'd65536;
  localparam logic [DATA_W-1:0]  HIST_INIT   = 24'd6554;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [MAX_ORDER-1:0][DATA_W-1:0] row_t;

  localparam row_t HIST_ROW = {MAX_ORDER{HIST_INIT}};

endpackage

`default_nettype wire

>>> rtl/per_pixel_temporal_iir_filter_top.sv
// Per-pixel temporal IIR filter: y = b0*x - sum a_k*y_k per pixel, Q7.16, saturated.
// Stages s1, s2, s3, then the output register; one request per cycle while out_ready is high.
// A request whose pixel matches one of the three in flight waits until its write-back lands.
// After rst every history slot of all 4096 pixels is set to 6554; in_ready stays low meanwhile.
// Configuration writes are taken at any time, including during the clear.
// Depends on pptif_pkg.
`timescale 1ns / 1ps
`default_nettype none

module per_pixel_temporal_iir_filter_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_write,
  input  logic [pptif_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pptif_pkg::DATA_W-1:0]         cfg_data,
  // input requests
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pptif_pkg::INDEX_W-1:0]        pixel_index,
  input  logic signed [pptif_pkg::DATA_W-1:0]  sample_value,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pptif_pkg::INDEX_W-1:0]        result_index,
  output logic signed [pptif_pkg::DATA_W-1:0]  filtered_value,
  output logic                                 saturated_flag
);

  localparam logic [pptif_pkg::ADDR_W-1:0] LAST_ADDR =
    pptif_pkg::ADDR_W'(pptif_pkg::PIXELS - 1);

  // configuration registers
  logic [pptif_pkg::ORDER_W-1:0] filter_order;
  pptif_pkg::data_t              input_gain;
  pptif_pkg::data_t              coef [pptif_pkg::NUM_COEF];

  // history memory and clear sweep
  pptif_pkg::row_t               mem [pptif_pkg::PIXELS];
  pptif_pkg::row_t               rd_row;
  logic                          clearing;
  logic [pptif_pkg::ADDR_W-1:0]  clr_addr;
  logic                          mem_we;
  logic [pptif_pkg::ADDR_W-1:0]  mem_waddr;
  pptif_pkg::row_t               mem_wdata;

  // stage 1: request registered, history row arriving
  logic                          s1_valid;
  logic [pptif_pkg::INDEX_W-1:0] s1_index;
  logic [pptif_pkg::ADDR_W-1:0]  s1_addr;
  pptif_pkg::data_t              s1_x;

  // stage 2: products
  logic                          s2_valid;
  logic [pptif_pkg::INDEX_W-1:0] s2_index;
  logic [pptif_pkg::ADDR_W-1:0]  s2_addr;
  pptif_pkg::row_t               s2_row;
  logic signed [pptif_pkg::PROD_W-1:0] s2_prod [pptif_pkg::MAX_ORDER+1];

  // stage 3: pair sums
  logic                          s3_valid;
  logic [pptif_pkg::INDEX_W-1:0] s3_index;
  logic [pptif_pkg::ADDR_W-1:0]  s3_addr;
  pptif_pkg::row_t               s3_row;
  logic signed [pptif_pkg::SUM_W-1:0] s3_pair [pptif_pkg::NPAIR];

  // handshake and flow control
  logic                          accept;
  logic                          addr_hit;
  logic [pptif_pkg::ADDR_W-1:0]  addr_in;
  logic                          out_free;
  logic                          s3_free;
  logic                          s2_free;
  logic                          s1_free;

  // datapath nets
  logic [pptif_pkg::ORDER_W-1:0] order_eff;
  logic signed [pptif_pkg::PROD_W-1:0] prod_next [pptif_pkg::MAX_ORDER+1];
  logic signed [pptif_pkg::SUM_W-1:0]  term [2*pptif_pkg::NPAIR];
  logic signed [pptif_pkg::SUM_W-1:0]  pair_next [pptif_pkg::NPAIR];
  logic signed [pptif_pkg::SUM_W-1:0]  acc;
  logic signed [pptif_pkg::SUM_W-1:0]  rnd;
  logic signed [pptif_pkg::SUM_W-1:0]  y_full;
  pptif_pkg::data_t              y_sat;
  logic                          sat_next;
  pptif_pkg::row_t               wb_row;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= pptif_pkg::ORDER_RESET;
      input_gain   <= pptif_pkg::GAIN_RESET;
      for (int k = 0; k < pptif_pkg::NUM_COEF; k++) begin
        coef[k] <= '0;
      end
    end else if (cfg_write) begin
      priority if (cfg_index == pptif_pkg::REG_ORDER) begin
        filter_order <= cfg_data[pptif_pkg::ORDER_W-1:0];
      end else if (cfg_index == pptif_pkg::REG_GAIN) begin
        input_gain <= cfg_data;
      end else if (cfg_index >= pptif_pkg::REG_COEF_BASE) begin
        coef[pptif_pkg::COEF_IDX_W'(cfg_index - pptif_pkg::REG_COEF_BASE)] <= cfg_data;
      end
    end
  end

  // order 0 acts as 1, anything past MAX_ORDER is clamped
  always_comb begin
    if (filter_order == '0) begin
      order_eff = pptif_pkg::ORDER_W'(1);
    end else if (filter_order > pptif_pkg::ORDER_W'(pptif_pkg::MAX_ORDER)) begin
      order_eff = pptif_pkg::ORDER_W'(pptif_pkg::MAX_ORDER);
    end else begin
      order_eff = filter_order;
    end
  end

  // ------------------------------------------------------------ flow control
  assign addr_in  = pptif_pkg::ADDR_W'(pixel_index % pptif_pkg::PIXELS);
  assign out_free = !out_valid || out_ready;
  assign s3_free  = !s3_valid || out_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;

  // same pixel still in flight: its row in memory is stale until write-back
  assign addr_hit = (s1_valid && s1_addr == addr_in) ||
                    (s2_valid && s2_addr == addr_in) ||
                    (s3_valid && s3_addr == addr_in);

  assign in_ready = !clearing && s1_free && !addr_hit;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
    end else begin
      if (s1_free) s1_valid <= accept;
      if (s2_free) s2_valid <= s1_valid;
      if (s3_free) s3_valid <= s2_valid;
      if (out_free) out_valid <= s3_valid;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) clearing <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------ memory
  assign mem_we    = clearing || (s3_valid && out_free);
  assign mem_waddr = clearing ? clr_addr : s3_addr;
  assign mem_wdata = clearing ? pptif_pkg::HIST_ROW : wb_row;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (accept) rd_row <= mem[addr_in];
  end

  // ------------------------------------------------------------- datapath
  // 24 x 24 signed products, operands sign-extended to the product width
  always_comb begin
    prod_next[0] = pptif_pkg::PROD_W'(input_gain) * pptif_pkg::PROD_W'(s1_x);
    for (int k = 0; k < pptif_pkg::MAX_ORDER; k++) begin
      if (pptif_pkg::ORDER_W'(k) < order_eff) begin
        prod_next[k+1] = pptif_pkg::PROD_W'(coef[k]) *
                         pptif_pkg::PROD_W'($signed(rd_row[k]));
      end else begin
        prod_next[k+1] = '0;
      end
    end
  end

  // feedforward term positive, feedback terms negated, padded to whole pairs
  always_comb begin
    for (int j = 0; j < 2 * pptif_pkg::NPAIR; j++) begin
      term[j] = '0;
    end
    term[0] = pptif_pkg::SUM_W'(s2_prod[0]);
    for (int k = 1; k <= pptif_pkg::MAX_ORDER; k++) begin
      term[k] = -(pptif_pkg::SUM_W'(s2_prod[k]));
    end
    for (int j = 0; j < pptif_pkg::NPAIR; j++) begin
      pair_next[j] = term[2*j] + term[2*j+1];
    end
  end

  // final sum, round half up, saturate
  always_comb begin
    acc = '0;
    for (int j = 0; j < pptif_pkg::NPAIR; j++) begin
      acc = acc + s3_pair[j];
    end
    rnd    = acc + pptif_pkg::SUM_W'(pptif_pkg::ROUND_HALF);
    y_full = rnd >>> pptif_pkg::FRAC_W;
    if (y_full > pptif_pkg::SUM_W'(pptif_pkg::SAT_MAX)) begin
      y_sat    = pptif_pkg::DATA_W'(pptif_pkg::SAT_MAX);
      sat_next = 1'b1;
    end else if (y_full < pptif_pkg::SUM_W'(pptif_pkg::SAT_MIN)) begin
      y_sat    = pptif_pkg::DATA_W'(pptif_pkg::SAT_MIN);
      sat_next = 1'b1;
    end else begin
      y_sat    = y_full[pptif_pkg::DATA_W-1:0];
      sat_next = 1'b0;
    end
    // every slot shifts regardless of the order in use
    wb_row[0] = y_sat;
    for (int k = 1; k < pptif_pkg::MAX_ORDER; k++) begin
      wb_row[k] = s3_row[k-1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_free && accept) begin
      s1_index <= pixel_index;
      s1_addr  <= addr_in;
      s1_x     <= sample_value;
    end
    if (s2_free && s1_valid) begin
      s2_index <= s1_index;
      s2_addr  <= s1_addr;
      s2_row   <= rd_row;
      for (int k = 0; k <= pptif_pkg::MAX_ORDER; k++) begin
        s2_prod[k] <= prod_next[k];
      end
    end
    if (s3_free && s2_valid) begin
      s3_index <= s2_index;
      s3_addr  <= s2_addr;
      s3_row   <= s2_row;
      for (int j = 0; j < pptif_pkg::NPAIR; j++) begin
        s3_pair[j] <= pair_next[j];
      end
    end
    if (out_free && s3_valid) begin
      result_index   <= s3_index;
      filtered_value <= y_sat;
      saturated_flag <= sat_next;
    end
  end

endmodule

`default_nettype wire
